FILE: hw/rtl/dnl_pkg.sv
`default_nettype none

package dnl_pkg;

  localparam int unsigned DATA_W     = 12;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [DATA_W-1:0]  FULL_SCALE = 12'd4095;
  localparam logic [TIMER_W-1:0] TIMER_MAX  = 16'd65535;

  localparam logic [DATA_W-1:0]  NIGHT_THR_RST = 12'd1000;
  localparam logic [DATA_W-1:0]  DAY_THR_RST   = 12'd2000;
  localparam logic [TIMER_W-1:0] STABLE_MS_RST = 16'd3000;
  localparam logic [TIMER_W-1:0] POLL_MS_RST   = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NIGHT_THR = 3'd0,
    CFG_DAY_THR   = 3'd1,
    CFG_STABLE_MS = 3'd2,
    CFG_POLL_MS   = 3'd3,
    CFG_INVERT    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_NIGHT = 2'd1,
    EV_DAY   = 2'd2
  } event_e;

  typedef struct packed {
    logic [DATA_W-1:0]  night_thr;
    logic [DATA_W-1:0]  day_thr;
    logic [TIMER_W-1:0] stable_ms;
    logic [TIMER_W-1:0] poll_ms;
    logic               invert;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [DATA_W-1:0] sample_value;
    logic              sample_ok;
  } item_t;

  typedef struct packed {
    event_e            event_res;
    logic              is_night;
    logic [DATA_W-1:0] adc_average;
    logic [DATA_W-1:0] light_level;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dnl_cfg_regs.sv
`default_nettype none

module dnl_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             we_i,
  input  wire logic [dnl_pkg::CFG_IDX_W-1:0]    idx_i,
  input  wire logic [dnl_pkg::CFG_DATA_W-1:0]   data_i,
  output dnl_pkg::cfg_t                         cfg_o
);

  dnl_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (dnl_pkg::cfg_idx_e'(idx_i))
        dnl_pkg::CFG_NIGHT_THR: cfg_d.night_thr = data_i[dnl_pkg::DATA_W-1:0];
        dnl_pkg::CFG_DAY_THR:   cfg_d.day_thr   = data_i[dnl_pkg::DATA_W-1:0];
        dnl_pkg::CFG_STABLE_MS: cfg_d.stable_ms = data_i[dnl_pkg::TIMER_W-1:0];
        dnl_pkg::CFG_POLL_MS:   cfg_d.poll_ms   = data_i[dnl_pkg::TIMER_W-1:0];
        dnl_pkg::CFG_INVERT:    cfg_d.invert    = data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.night_thr <= dnl_pkg::NIGHT_THR_RST;
      cfg_q.day_thr   <= dnl_pkg::DAY_THR_RST;
      cfg_q.stable_ms <= dnl_pkg::STABLE_MS_RST;
      cfg_q.poll_ms   <= dnl_pkg::POLL_MS_RST;
      cfg_q.invert    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dnl_in_reg.sv
`default_nettype none

module dnl_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire dnl_pkg::item_t  in_item_i,
  input  wire logic            take_i,
  output logic                 valid_o,
  output dnl_pkg::item_t       item_o
);

  logic           valid_q, valid_d;
  dnl_pkg::item_t item_q;
  logic           load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dnl_core.sv
`default_nettype none

module dnl_core #(
  parameter int unsigned SAMPLES = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dnl_pkg::cfg_t    cfg_i,
  input  wire logic             step_i,
  input  wire dnl_pkg::item_t   item_i,
  output dnl_pkg::result_t      result_o
);

  localparam int unsigned CntW     = $clog2(SAMPLES + 1);
  localparam int unsigned SumW     = dnl_pkg::DATA_W + $clog2(SAMPLES);
  localparam int unsigned DivShift = SumW + 3;
  localparam int unsigned ProdW    = SumW + DivShift + 1;
  localparam logic [DivShift:0] DivMult =
    (DivShift + 1)'((2 ** DivShift + SAMPLES - 1) / SAMPLES);
  localparam logic [CntW-1:0] SamplesCnt = CntW'(SAMPLES);

  logic                        night_q, night_d;
  logic                        pend_q, pend_d;
  logic [dnl_pkg::TIMER_W-1:0] poll_tmr_q, poll_tmr_d;
  logic [dnl_pkg::TIMER_W-1:0] chg_tmr_q, chg_tmr_d;
  logic [dnl_pkg::DATA_W-1:0]  avg_q, avg_d;
  logic [dnl_pkg::DATA_W-1:0]  level_q, level_d;
  logic [SumW-1:0]             sum_q, sum_d;
  logic [CntW-1:0]             cnt_q, cnt_d;

  logic                        poll_due;
  logic [SumW-1:0]             sum_base;
  logic [SumW-1:0]             sum_acc;
  logic [CntW-1:0]             cnt_inc;
  logic [ProdW-1:0]            prod;
  logic                        finish;
  logic [dnl_pkg::DATA_W-1:0]  level;
  logic                        cand;
  dnl_pkg::event_e             ev;

  assign poll_due = (cnt_q != '0) || (poll_tmr_q >= cfg_i.poll_ms);
  assign sum_base = (cnt_q == '0) ? '0 : sum_q;
  assign sum_acc  = sum_base + SumW'(item_i.sample_value);
  assign cnt_inc  = cnt_q + 1'b1;
  assign prod     = ProdW'(sum_acc) * ProdW'(DivMult);

  always_comb begin
    night_d    = night_q;
    pend_d     = pend_q;
    poll_tmr_d = poll_tmr_q;
    chg_tmr_d  = chg_tmr_q;
    avg_d      = avg_q;
    level_d    = level_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    finish     = 1'b0;
    ev         = dnl_pkg::EV_NONE;
    level      = '0;
    cand       = 1'b0;

    if (item_i.cmd == dnl_pkg::CMD_TICK) begin
      poll_tmr_d = (poll_tmr_q == dnl_pkg::TIMER_MAX) ? poll_tmr_q : poll_tmr_q + 1'b1;
      chg_tmr_d  = (chg_tmr_q == dnl_pkg::TIMER_MAX) ? chg_tmr_q : chg_tmr_q + 1'b1;
    end else if (poll_due) begin
      if (cnt_q == '0) begin
        poll_tmr_d = '0;
      end
      if (!item_i.sample_ok) begin
        sum_d  = '0;
        cnt_d  = '0;
        finish = 1'b1;
      end else if (cnt_inc == SamplesCnt) begin
        avg_d  = prod[DivShift +: dnl_pkg::DATA_W];
        sum_d  = '0;
        cnt_d  = '0;
        finish = 1'b1;
      end else begin
        sum_d = sum_acc;
        cnt_d = cnt_inc;
      end
    end

    if (finish) begin
      level   = cfg_i.invert ? (dnl_pkg::FULL_SCALE - avg_d) : avg_d;
      level_d = level;
      cand    = night_q;
      if (level < cfg_i.night_thr) begin
        cand = 1'b1;
      end else if (level > cfg_i.day_thr) begin
        cand = 1'b0;
      end
      if (cand == night_q) begin
        pend_d = night_q;
      end else if (cand != pend_q) begin
        pend_d    = cand;
        chg_tmr_d = '0;
      end else if (chg_tmr_q >= cfg_i.stable_ms) begin
        night_d = cand;
        ev      = cand ? dnl_pkg::EV_NIGHT : dnl_pkg::EV_DAY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      night_q    <= 1'b0;
      pend_q     <= 1'b0;
      poll_tmr_q <= '0;
      chg_tmr_q  <= '0;
      avg_q      <= '0;
      level_q    <= dnl_pkg::DAY_THR_RST;
      sum_q      <= '0;
      cnt_q      <= '0;
    end else if (step_i) begin
      night_q    <= night_d;
      pend_q     <= pend_d;
      poll_tmr_q <= poll_tmr_d;
      chg_tmr_q  <= chg_tmr_d;
      avg_q      <= avg_d;
      level_q    <= level_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
    end
  end

  assign result_o.event_res   = ev;
  assign result_o.is_night    = night_d;
  assign result_o.adc_average = avg_d;
  assign result_o.light_level = level_d;

endmodule

`default_nettype wire

FILE: hw/rtl/dnl_out_reg.sv
`default_nettype none

module dnl_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  output logic                  ready_o,
  input  wire dnl_pkg::result_t result_i,
  output logic                  valid_o,
  input  wire logic             out_ready_i,
  output dnl_pkg::result_t      result_o
);

  logic             valid_q, valid_d;
  dnl_pkg::result_t result_q;

  assign ready_o = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: hw/rtl/day_night_light_detector.sv
// A request waits in the input register, its result in the result register.
// Throughput: one request per cycle unless a result waits downstream; each
// request is finished combinationally between the input and result registers.
// While a result waits downstream, the input register still takes one request.
// Reset is asynchronous, active low; it clears both valid flags and restores
// the configuration and the mode state, while the data registers are not reset.
`default_nettype none

module day_night_light_detector #(
  parameter int unsigned SAMPLES = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [dnl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [dnl_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [11:0] sample_value, [12] sample_ok, [15:13] zero.
  input  wire logic [dnl_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [0] cmd.
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [1:0] event_res, [2] is_night, [14:3] adc_average, [26:15] light_level,
  // [31:27] zero.
  output logic [dnl_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);

  dnl_pkg::cfg_t    cfg;
  dnl_pkg::item_t   in_item;
  dnl_pkg::item_t   item;
  dnl_pkg::result_t result;
  dnl_pkg::result_t out_result;
  logic             item_valid;
  logic             out_free;
  logic             step;

  assign in_item.cmd          = dnl_pkg::cmd_e'(s_axis_tuser);
  assign in_item.sample_value = s_axis_tdata[11:0];
  assign in_item.sample_ok    = s_axis_tdata[12];

  assign step = item_valid && out_free;

  dnl_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  dnl_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .take_i     (step),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  dnl_core #(
    .SAMPLES (SAMPLES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (item),
    .result_o (result)
  );

  dnl_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .ready_o     (out_free),
    .result_i    (result),
    .valid_o     (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_result)
  );

  assign m_axis_tdata = {5'd0, out_result.light_level, out_result.adc_average,
                         out_result.is_night, out_result.event_res};

endmodule

`default_nettype wire

FILE: hw/rtl/dnl_checker.sv
`default_nettype none

module dnl_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [dnl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // A night event always reports the night mode it just committed.
  a_night_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == dnl_pkg::EV_NIGHT) |-> m_axis_tdata[2])
    else $error("night event without night mode");

  // A day event always reports the day mode it just committed.
  a_day_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == dnl_pkg::EV_DAY) |-> !m_axis_tdata[2])
    else $error("day event without day mode");

  // The input side stalls only while a result is held back downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && !s_axis_tready) |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with the result register free");

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

endmodule

bind day_night_light_detector dnl_checker u_dnl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
